FILE: hdl/tts_pkg.sv
// shared types and constants for the timed task scheduler
// no dependencies; imported by every module of the block but the deadline store
package tts_pkg;

    localparam int NUM_TASKS   = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int TASK_AW     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int FUNC_W      = 3;
    localparam int ID_W        = 6;
    localparam int VALUE_W     = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [TASK_AW-1:0]     t_slot;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD     = 3'd0,
        FUNC_FIRE    = 3'd1,
        FUNC_ADVANCE = 3'd2,
        FUNC_QUERY   = 3'd3,
        FUNC_CLEAR   = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        KIND_FIRED = 3'd0,
        KIND_DONE  = 3'd1,
        KIND_ADD   = 3'd2,
        KIND_SLICE = 3'd3,
        KIND_COUNT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [ID_W-1:0]     fired_task;
        logic [VALUE_W-1:0]  value;
        logic                shorten_remaining;
        logic                last;
    } t_result;

    typedef struct packed {
        logic   wr_en;
        t_slot  wr_addr;
        t_count wr_data;
        t_slot  rd_addr;
    } t_ram_req;

endpackage

FILE: hdl/timed_task_scheduler_unit.sv
// timed task scheduler top level: deadline store, sequencer and output register
// depends on tts_pkg, tts_deadline_ram, tts_sequencer, tts_out_stage
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries one operation per
//   transaction: add, fire, advance, query or clear, with its operands.
//   output channel (o_out_valid / i_out_ready) returns result transactions;
//   o_last marks the final result of an operation. clear and unused codes
//   give no result.
//   one operation is handled at a time. add and query pass through an
//   execute state, then a finish state that hands the result to the
//   output register. fire and advance walk the deadline store one slot a
//   cycle through its single read port, except that a fire holds on a slot
//   whose fired task waits on a full output register; the final result of
//   every operation with a result also waits on a full output register.
//   a stalled receiver holds the output register; a fire scan waits on it.
//   reset (synchronous, active low) clears all active flags and the slice
//   end count; stored deadlines are only read for active slots.
module timed_task_scheduler_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tts_pkg::FUNC_W-1:0]  i_func,
    input  logic [tts_pkg::ID_W-1:0]    i_task_id,
    input  logic [tts_pkg::VALUE_W-1:0] i_delay,
    input  logic [tts_pkg::VALUE_W-1:0] i_budget,
    input  logic [tts_pkg::VALUE_W-1:0] i_remaining,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_kind,
    output logic [tts_pkg::ID_W-1:0]    o_fired_task,
    output logic [tts_pkg::VALUE_W-1:0] o_value,
    output logic                        o_shorten_remaining,
    output logic                        o_last
);
    import tts_pkg::*;

    t_ram_req ram_req;
    t_count   rd_data;
    logic     out_free;
    logic     push;
    t_result  push_result;
    t_result  out_result;

    tts_deadline_ram #(
        .DEPTH (NUM_TASKS),
        .WIDTH (COUNT_WIDTH),
        .AW    (TASK_AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    tts_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_task_id   (i_task_id),
        .i_delay     (i_delay),
        .i_budget    (i_budget),
        .i_remaining (i_remaining),
        .o_ram       (ram_req),
        .i_rd_data   (rd_data),
        .i_out_free  (out_free),
        .o_push      (push),
        .o_result    (push_result)
    );

    tts_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (push_result),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (out_result)
    );

    assign o_kind              = out_result.kind;
    assign o_fired_task        = out_result.fired_task;
    assign o_value             = out_result.value;
    assign o_shorten_remaining = out_result.shorten_remaining;
    assign o_last              = out_result.last;

endmodule

FILE: hdl/tts_deadline_ram.sv
// deadline store: one write port, one read port, registered read data
// generic, no package dependency
module tts_deadline_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

FILE: hdl/tts_out_stage.sv
// result output register: holds one result transaction until the receiver takes it
// depends on tts_pkg for the result struct
module tts_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tts_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tts_pkg::t_result o_result
);
    import tts_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_result;
        end
    end

endmodule

FILE: hdl/tts_sequencer.sv
// operation sequencer: holds slice end and active flags, scans the deadline store
// depends on tts_pkg; drives tts_deadline_ram and tts_out_stage
module tts_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [tts_pkg::FUNC_W-1:0]  i_func,
    input  logic [tts_pkg::ID_W-1:0]    i_task_id,
    input  logic [tts_pkg::VALUE_W-1:0] i_delay,
    input  logic [tts_pkg::VALUE_W-1:0] i_budget,
    input  logic [tts_pkg::VALUE_W-1:0] i_remaining,
    output tts_pkg::t_ram_req         o_ram,
    input  tts_pkg::t_count           i_rd_data,
    input  logic                      i_out_free,
    output logic                      o_push,
    output tts_pkg::t_result          o_result
);
    import tts_pkg::*;

    t_state r_state, n_state;

    logic [FUNC_W-1:0] r_func;
    logic [ID_W-1:0]   r_id;
    t_count            r_delay, r_rem;

    logic [NUM_TASKS-1:0] r_active, n_active;
    t_count               r_slice, n_slice;
    t_count               r_min, n_min;
    t_slot                r_idx, n_idx;
    logic [VALUE_W-1:0]   r_res_value, n_res_value;
    logic                 r_res_short, n_res_short;

    logic   accept;
    logic   id_ok;
    logic   last_slot;
    logic   hit;
    t_count when_cnt, gap_cnt;

    assign accept    = (r_state == S_IDLE) && i_in_valid;
    assign id_ok     = r_id < ID_W'(NUM_TASKS);
    assign last_slot = r_idx == t_slot'(NUM_TASKS - 1);
    assign when_cnt  = r_slice - r_rem + r_delay;
    assign gap_cnt   = i_rd_data - r_slice;
    assign hit       = r_active[r_idx] && (i_rd_data == r_slice);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_FIRE || i_func == FUNC_ADVANCE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (r_func == FUNC_ADD || r_func == FUNC_QUERY) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!(r_func == FUNC_FIRE && hit && !i_out_free) && last_slot) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_ready        = (r_state == S_IDLE);
        o_ram.wr_en       = 1'b0;
        o_ram.wr_addr     = r_id[TASK_AW-1:0];
        o_ram.wr_data     = when_cnt;
        o_ram.rd_addr     = '0;
        o_push            = 1'b0;
        o_result          = '0;
        o_result.kind     = KIND_FIRED;
        n_active          = r_active;
        n_slice           = r_slice;
        n_min             = r_min;
        n_idx             = r_idx;
        n_res_value       = r_res_value;
        n_res_short       = r_res_short;
        case (r_state)
            S_IDLE: begin
                // slot 0 is read here so its deadline is ready when a scan starts
                n_idx = '0;
                n_min = COUNT_WIDTH'(i_budget);
            end
            S_EXEC: begin
                case (r_func)
                    FUNC_ADD: begin
                        n_res_value = VALUE_W'(r_rem);
                        n_res_short = 1'b0;
                        if (id_ok) begin
                            o_ram.wr_en = 1'b1;
                            n_active[r_id[TASK_AW-1:0]] = 1'b1;
                            if (r_rem > r_delay) begin
                                n_slice     = when_cnt;
                                n_res_value = VALUE_W'(r_delay);
                                n_res_short = 1'b1;
                            end
                        end
                    end
                    FUNC_QUERY: begin
                        n_res_value = VALUE_W'(r_slice - r_rem);
                        n_res_short = 1'b0;
                    end
                    FUNC_CLEAR: begin
                        n_active = '0;
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                o_ram.rd_addr = r_idx;
                if (r_func == FUNC_FIRE) begin
                    if (!(hit && !i_out_free)) begin
                        if (hit) begin
                            o_push              = 1'b1;
                            o_result.kind       = KIND_FIRED;
                            o_result.fired_task = ID_W'(r_idx);
                            n_active[r_idx]     = 1'b0;
                        end
                        n_res_value = '0;
                        n_res_short = 1'b0;
                        if (!last_slot) begin
                            n_idx         = r_idx + 1'b1;
                            o_ram.rd_addr = r_idx + 1'b1;
                        end
                    end
                end else begin
                    if (r_active[r_idx] && gap_cnt < r_min) begin
                        n_min = gap_cnt;
                    end
                    n_res_short = 1'b0;
                    if (last_slot) begin
                        n_slice     = r_slice + n_min;
                        n_res_value = VALUE_W'(n_min);
                    end else begin
                        n_idx         = r_idx + 1'b1;
                        o_ram.rd_addr = r_idx + 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_push                     = 1'b1;
                    o_result.value             = r_res_value;
                    o_result.shorten_remaining = r_res_short;
                    o_result.last              = 1'b1;
                    case (r_func)
                        FUNC_ADD:     o_result.kind = KIND_ADD;
                        FUNC_FIRE:    o_result.kind = KIND_DONE;
                        FUNC_ADVANCE: o_result.kind = KIND_SLICE;
                        FUNC_QUERY:   o_result.kind = KIND_COUNT;
                        default:      o_result.kind = KIND_DONE;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_slice  <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_slice  <= n_slice;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min       <= n_min;
        r_idx       <= n_idx;
        r_res_value <= n_res_value;
        r_res_short <= n_res_short;
        if (accept) begin
            r_func   <= i_func;
            r_id     <= i_task_id;
            r_delay  <= COUNT_WIDTH'(i_delay);
            r_rem    <= COUNT_WIDTH'(i_remaining);
        end
    end

endmodule

FILE: bench/tb_timed_task_scheduler_unit.sv
// testbench for timed_task_scheduler_unit: random and directed operations with a shadow
// scheduler that predicts every result transaction, checked in order by a monitor
// depends on tts_pkg and the timed_task_scheduler_unit rtl
module tb_timed_task_scheduler_unit;
    import tts_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 11;
    localparam int TARGET_OPS       = 330;
    localparam int TAIL_CYCLES      = 3 * (NUM_TASKS + 2);
    localparam int TIMEOUT_CYCLES   = 500000;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int ID_MAX           = (1 << ID_W) - 1;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = FUNC_W'(FUNC_CLEAR + 1);
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = '1;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    task_id;
        logic [VALUE_W-1:0] delay;
        logic [VALUE_W-1:0] budget;
        logic [VALUE_W-1:0] remaining;
        int unsigned        pre_gap;
        bit                 drain_first;
    } t_sched_op;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [FUNC_W-1:0]  i_func = '0;
    logic [ID_W-1:0]    i_task_id = '0;
    logic [VALUE_W-1:0] i_delay = '0;
    logic [VALUE_W-1:0] i_budget = '0;
    logic [VALUE_W-1:0] i_remaining = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_kind;
    logic [ID_W-1:0]    o_fired_task;
    logic [VALUE_W-1:0] o_value;
    logic               o_shorten_remaining;
    logic               o_last;

    // shadow copy of the scheduler state
    logic [NUM_TASKS-1:0] sh_active = '0;
    t_count               sh_deadline [NUM_TASKS];
    t_count               sh_slice_end = '0;

    t_sched_op   op_queue[$];
    t_result     owed_results[$];
    t_sched_op   drv_cur;
    t_result     want;
    int unsigned drv_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_roll;
    bit          long_hold_done = 1'b0;
    bit          calm = 1'b1;
    int unsigned ops_queued = 0;
    int unsigned ops_counted = 0;
    int unsigned ops_sent = 0;
    int unsigned results_seen = 0;
    int unsigned fired_seen = 0;
    int unsigned errors = 0;

    timed_task_scheduler_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_task_id           (i_task_id),
        .i_delay             (i_delay),
        .i_budget            (i_budget),
        .i_remaining         (i_remaining),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_fired_task        (o_fired_task),
        .o_value             (o_value),
        .o_shorten_remaining (o_shorten_remaining),
        .o_last              (o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    task automatic add_op(input int unsigned func, input int unsigned id,
                          input logic [VALUE_W-1:0] dly, input logic [VALUE_W-1:0] bud,
                          input logic [VALUE_W-1:0] rem, input bit drain);
        t_sched_op   op;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        op.func        = FUNC_W'(func);
        op.task_id     = ID_W'(id);
        op.delay       = dly;
        op.budget      = bud;
        op.remaining   = rem;
        op.drain_first = drain;
        if (calm || roll < 65)
            op.pre_gap = 0;
        else if (roll < 92)
            op.pre_gap = $urandom_range(1, 3);
        else
            op.pre_gap = $urandom_range(8, 40);
        op_queue.push_back(op);
        ops_queued++;
        if (op.func <= FUNC_CLEAR)
            ops_counted++;
    endtask

    // applies one operation to the shadow state and queues the results it owes
    task automatic schedule_step(input t_sched_op op);
        t_count  when;
        t_count  gap;
        t_count  step;
        t_result r;
        int      slot;
        r = '0;
        r.last = 1'b1;
        case (op.func)
            FUNC_ADD: begin
                when = sh_slice_end - op.remaining + op.delay;
                r.kind  = KIND_ADD;
                r.value = op.remaining;
                if (op.task_id < NUM_TASKS) begin
                    sh_deadline[op.task_id[TASK_AW-1:0]] = when;
                    sh_active[op.task_id[TASK_AW-1:0]]   = 1'b1;
                    // caller has more left than the new deadline allows
                    if (op.remaining > op.delay) begin
                        sh_slice_end        = when;
                        r.value             = op.delay;
                        r.shorten_remaining = 1'b1;
                    end
                end
                owed_results.push_back(r);
            end
            FUNC_FIRE: begin
                for (slot = 0; slot < NUM_TASKS; slot++) begin
                    if (sh_active[slot] && sh_deadline[slot] == sh_slice_end) begin
                        sh_active[slot] = 1'b0;
                        r = '0;
                        r.kind       = KIND_FIRED;
                        r.fired_task = slot[ID_W-1:0];
                        owed_results.push_back(r);
                    end
                end
                r = '0;
                r.kind = KIND_DONE;
                r.last = 1'b1;
                owed_results.push_back(r);
            end
            FUNC_ADVANCE: begin
                step = op.budget;
                for (slot = 0; slot < NUM_TASKS; slot++) begin
                    if (sh_active[slot]) begin
                        gap = sh_deadline[slot] - sh_slice_end;
                        if (gap < step)
                            step = gap;
                    end
                end
                sh_slice_end = sh_slice_end + step;
                r.kind  = KIND_SLICE;
                r.value = step;
                owed_results.push_back(r);
            end
            FUNC_QUERY: begin
                r.kind  = KIND_COUNT;
                r.value = sh_slice_end - op.remaining;
                owed_results.push_back(r);
            end
            FUNC_CLEAR: sh_active = '0;
            default: ;
        endcase
    endtask

    // sender: each queued item may ask for a gap or a full drain before it goes out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                schedule_step(drv_cur);
                ops_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_in_valid <= 1'b0;
                end else if (op_queue.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (op_queue[0].pre_gap > 0) begin
                    drv_gap = op_queue[0].pre_gap - 1;
                    op_queue[0].pre_gap = 0;
                    i_in_valid <= 1'b0;
                end else if (op_queue[0].drain_first && owed_results.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    drv_cur = op_queue.pop_front();
                    i_func      <= drv_cur.func;
                    i_task_id   <= drv_cur.task_id;
                    i_delay     <= drv_cur.delay;
                    i_budget    <= drv_cur.budget;
                    i_remaining <= drv_cur.remaining;
                    i_in_valid  <= 1'b1;
                end
            end
        end
    end

    // receiver: checks each result transaction against the oldest owed one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (o_kind == KIND_FIRED)
                    fired_seen++;
                if (owed_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing owed: kind %0d task %0d value %h last %b",
                             $time, o_kind, o_fired_task, o_value, o_last);
                end else begin
                    want = owed_results.pop_front();
                    if (o_kind !== want.kind) begin
                        errors++;
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind, o_kind);
                    end
                    if (o_fired_task !== want.fired_task) begin
                        errors++;
                        $display("%0t: fired_task expected %0d actual %0d",
                                 $time, want.fired_task, o_fired_task);
                    end
                    if (o_value !== want.value) begin
                        errors++;
                        $display("%0t: value expected %h actual %h", $time, want.value, o_value);
                    end
                    if (o_shorten_remaining !== want.shorten_remaining) begin
                        errors++;
                        $display("%0t: shorten_remaining expected %b actual %b",
                                 $time, want.shorten_remaining, o_shorten_remaining);
                    end
                    if (o_last !== want.last) begin
                        errors++;
                        $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                    end
                end
            end
            rx_roll = $urandom_range(0, 99);
            if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                // long back-pressure so the block fills up and holds off its input
                long_hold_done = 1'b1;
                rx_stall = LONG_HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if ((results_seen / 64) % 3 == 1 || rx_roll < 70) begin
                i_out_ready <= 1'b1;
            end else if (rx_roll < 95) begin
                rx_stall = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                rx_stall = $urandom_range(7, 29);
                i_out_ready <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned k;
        int unsigned j;
        int unsigned base_dly;
        int          f;
        bit          same_dl;
        bit          drain;
        bit          first;
        logic [ID_W-1:0]    id;
        logic [VALUE_W-1:0] dly;
        logic [VALUE_W-1:0] rem;

        // directed: field extremes, every operation and the corner cases
        calm = 1'b1;
        add_op(FUNC_QUERY, $urandom, $urandom, $urandom, '0, 1'b0);
        add_op(FUNC_QUERY, ID_MAX, $urandom, $urandom, '1, 1'b0);
        add_op(FUNC_ADD, 0, 1, $urandom, 0, 1'b0);
        add_op(FUNC_ADD, 1, '1, 1, '1, 1'b0);
        add_op(FUNC_ADD, 2, 5, '1, 100, 1'b0);
        // slot out of range, each with a shortening request that is not granted
        add_op(FUNC_ADD, ID_MAX, 3, $urandom, 50, 1'b0);
        add_op(FUNC_ADD, NUM_TASKS, 0, $urandom, 7, 1'b0);
        // zero delay shortens to nothing and lands on the slice end
        add_op(FUNC_ADD, 3, 0, $urandom, 9, 1'b0);
        add_op(FUNC_ADVANCE, $urandom, $urandom, 0, $urandom, 1'b0);
        add_op(FUNC_FIRE, $urandom, $urandom, $urandom, $urandom, 1'b0);
        // deadline sitting on the slice end, unfired: advance gives zero
        add_op(FUNC_ADD, 4, 0, $urandom, 0, 1'b0);
        add_op(FUNC_ADVANCE, $urandom, $urandom, '1, $urandom, 1'b0);
        add_op(FUNC_FIRE, $urandom, $urandom, $urandom, $urandom, 1'b0);
        add_op(FUNC_ADVANCE, $urandom, $urandom, '1, $urandom, 1'b0);
        add_op(FUNC_FIRE, $urandom, $urandom, $urandom, $urandom, 1'b0);
        for (f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
            add_op(f[FUNC_W-1:0], $urandom, $urandom, $urandom, $urandom, 1'b0);
        add_op(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0);
        add_op(FUNC_ADVANCE, $urandom, $urandom, 1, $urandom, 1'b0);
        add_op(FUNC_QUERY, $urandom, $urandom, $urandom, 12345, 1'b0);

        // random: mostly schedule / advance / fire rounds, some plain noise
        first = 1'b1;
        while (ops_counted < TARGET_OPS) begin
            calm  = ($urandom_range(0, 3) == 0);
            drain = first || ($urandom_range(0, 7) == 0);
            first = 1'b0;
            if ($urandom_range(0, 4) == 0) begin
                k = $urandom_range(3, 8);
                repeat (k) begin
                    add_op($urandom_range(0, FUNC_SPARE_LAST), $urandom, $urandom, $urandom,
                           $urandom, drain);
                    drain = 1'b0;
                end
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    add_op(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, drain);
                    drain = 1'b0;
                end
                // shared deadline on every slot gives the longest fire burst
                same_dl  = ($urandom_range(0, 3) == 0);
                base_dly = $urandom_range(1, 40);
                k = same_dl ? NUM_TASKS : $urandom_range(1, NUM_TASKS);
                for (j = 0; j < k; j++) begin
                    if ($urandom_range(0, 9) == 0)
                        id = ID_W'($urandom_range(NUM_TASKS, ID_MAX));
                    else if (same_dl)
                        id = ID_W'(j);
                    else
                        id = ID_W'($urandom_range(0, NUM_TASKS - 1));
                    if (same_dl) begin
                        dly = base_dly;
                        rem = 0;
                    end else begin
                        dly = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 40);
                        rem = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 60) : 0;
                    end
                    add_op(FUNC_ADD, id, dly, $urandom, rem, drain);
                    drain = 1'b0;
                end
                repeat ($urandom_range(1, 4)) begin
                    add_op(FUNC_ADVANCE, $urandom, $urandom,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom,
                           $urandom, 1'b0);
                    add_op(FUNC_FIRE, $urandom, $urandom, $urandom, $urandom, 1'b0);
                    if ($urandom_range(0, 2) == 0)
                        add_op(FUNC_QUERY, $urandom, $urandom, $urandom,
                               $urandom_range(0, 100), 1'b0);
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_sent != ops_queued) @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d operations (%0d counted), got %0d results of which %0d fired tasks",
                 ops_sent, ops_counted, results_seen, fired_seen);
        $display("long receiver hold-off seen: %0d, mismatches: %0d", long_hold_done, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("timeout after %0d cycles, %0d results still owed",
                 TIMEOUT_CYCLES, owed_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/tts_pkg.sv
hdl/tts_deadline_ram.sv
hdl/tts_out_stage.sv
hdl/tts_sequencer.sv
hdl/timed_task_scheduler_unit.sv
bench/tb_timed_task_scheduler_unit.sv
